@@ rtl/yuv_pair_to_rgb_converter_assert.svh @@
// assertion macros for the checker file
`ifndef YUV_PAIR_TO_RGB_CONVERTER_ASSERT_SVH
`define YUV_PAIR_TO_RGB_CONVERTER_ASSERT_SVH

// property checked at every rising edge, abandoned while reset is high
`define YPRGB_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define YPRGB_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/yprgb_pkg.sv @@
`timescale 1ns / 1ps
package yprgb_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes, byte address is 4 times the index
   localparam logic [1:0] REG_CHROMA_MODE = 2'd0;
   localparam logic [1:0] REG_LUMA_ONLY   = 2'd1;
   localparam logic [1:0] REG_REDUCE_565  = 2'd2;

   localparam logic [7:0] CHROMA_ZERO = 8'd128;

   localparam logic signed [17:0] COEF_B_U = 18'sd443;
   localparam logic signed [17:0] COEF_G_V = 18'sd179;
   localparam logic signed [17:0] COEF_G_U = 18'sd86;
   localparam logic signed [17:0] COEF_R_V = 18'sd351;

   typedef struct packed {
      logic chroma_mode;
      logic luma_only;
      logic reduce_565;
   } cfg_type;

   // chroma offsets shared by both pixels of a pair
   typedef struct packed {
      logic signed [9:0] blue;
      logic signed [9:0] green;
      logic signed [9:0] red;
   } offset_type;

   // clamp a signed channel value to 0..255
   function automatic logic [7:0] clamp8(input logic signed [10:0] x);
      logic [7:0] res;
      if (x[10]) begin
         res = 8'd0;
      end else if (x[9:8] != 2'b00) begin
         res = 8'd255;
      end else begin
         res = x[7:0];
      end
      return res;
   endfunction

endpackage

@@ rtl/yprgb_csr.sv @@
`timescale 1ns / 1ps
module yprgb_csr
   import yprgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_CHROMA_MODE: cfg_in.chroma_mode = csr_pwdata[0];
            REG_LUMA_ONLY:   cfg_in.luma_only   = csr_pwdata[0];
            REG_REDUCE_565:  cfg_in.reduce_565  = csr_pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CHROMA_MODE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.chroma_mode};
         REG_LUMA_ONLY:   csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.luma_only};
         REG_REDUCE_565:  csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.reduce_565};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/yprgb_chroma.sv @@
`timescale 1ns / 1ps
module yprgb_chroma
   import yprgb_pkg::*;
(
   input  logic [7:0] cb_first,
   input  logic [7:0] cr_first,
   input  logic [7:0] cb_second,
   input  logic [7:0] cr_second,
   input  cfg_type    cfg,
   output offset_type ofs
);

   logic [8:0]         cb_sum;
   logic [8:0]         cr_sum;
   logic [7:0]         u;
   logic [7:0]         v;
   logic signed [8:0]  du;
   logic signed [8:0]  dv;
   logic signed [17:0] du_x;
   logic signed [17:0] dv_x;
   logic signed [17:0] prod_b;
   logic signed [17:0] prod_g;
   logic signed [17:0] prod_r;

   assign cb_sum = {1'b0, cb_first} + {1'b0, cb_second};
   assign cr_sum = {1'b0, cr_first} + {1'b0, cr_second};

   always_comb begin
      if (cfg.luma_only) begin
         u = CHROMA_ZERO;
         v = CHROMA_ZERO;
      end else if (cfg.chroma_mode) begin
         u = cb_sum[8:1];
         v = cr_sum[8:1];
      end else begin
         u = cb_first;
         v = cr_first;
      end
   end

   assign du   = $signed({1'b0, u}) - $signed({1'b0, CHROMA_ZERO});
   assign dv   = $signed({1'b0, v}) - $signed({1'b0, CHROMA_ZERO});
   assign du_x = $signed({{9{du[8]}}, du});
   assign dv_x = $signed({{9{dv[8]}}, dv});

   // constant multiplies, then arithmetic shift by 8 via bit select
   assign prod_b = du_x * COEF_B_U;
   assign prod_g = dv_x * COEF_G_V + du_x * COEF_G_U;
   assign prod_r = dv_x * COEF_R_V;

   assign ofs.blue  = prod_b[17:8];
   assign ofs.green = prod_g[17:8];
   assign ofs.red   = prod_r[17:8];

endmodule

@@ rtl/yprgb_pixel.sv @@
`timescale 1ns / 1ps
module yprgb_pixel
   import yprgb_pkg::*;
(
   input  logic [7:0] luma,
   input  offset_type ofs,
   input  logic       reduce_565,
   output logic [7:0] blue,
   output logic [7:0] green,
   output logic [7:0] red
);

   logic signed [10:0] y_x;
   logic signed [10:0] b_sum;
   logic signed [10:0] g_sum;
   logic signed [10:0] r_sum;
   logic [7:0]         b_clamp;
   logic [7:0]         g_clamp;
   logic [7:0]         r_clamp;

   assign y_x   = $signed({3'b000, luma});
   assign b_sum = y_x + $signed({ofs.blue[9], ofs.blue});
   assign g_sum = y_x - $signed({ofs.green[9], ofs.green});
   assign r_sum = y_x + $signed({ofs.red[9], ofs.red});

   assign b_clamp = clamp8(b_sum);
   assign g_clamp = clamp8(g_sum);
   assign r_clamp = clamp8(r_sum);

   // 5-6-5 drops the low bits of each channel
   assign blue  = reduce_565 ? {3'b000, b_clamp[7:3]} : b_clamp;
   assign green = reduce_565 ? {2'b00, g_clamp[7:2]}  : g_clamp;
   assign red   = reduce_565 ? {3'b000, r_clamp[7:3]} : r_clamp;

endmodule

@@ rtl/yuv_pair_to_rgb_converter.sv @@
`timescale 1ns / 1ps
// yuv pixel pair to rgb converter, integer bt.601
// input channel: a word (two lumas and up to two chroma pairs) is taken at a
//   rising edge with start high and busy low; busy is always low, so a word
//   can be offered in every cycle
// result channel: rsp_valid marks the six rgb channels for exactly one cycle;
//   the receiver takes them at the end of that cycle and cannot stall, so
//   nothing is ever held back or queued
// path: a word taken at a rising edge goes into the input register, then
//   its result goes into the result register and is shown on the result
//   channel from there
// throughput: one word per cycle, the whole conversion sits between the
//   input register and the result register
// csr port: apb-style, chroma_mode at 0x0, luma_only at 0x4, reduce_565 at
//   0x8; only bit 0 is used; write the registers only while no word is in
//   flight
// reset: synchronous, clears the csr registers to 0 and drops both valid flags; data registers are not reset
module yuv_pair_to_rgb_converter
   import yprgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  start,
   output logic                  busy,
   input  logic [7:0]            req_luma_first,
   input  logic [7:0]            req_luma_second,
   input  logic [7:0]            req_cb_first,
   input  logic [7:0]            req_cr_first,
   input  logic [7:0]            req_cb_second,
   input  logic [7:0]            req_cr_second,
   // result channel
   output logic                  rsp_valid,
   output logic [7:0]            rsp_blue_first,
   output logic [7:0]            rsp_green_first,
   output logic [7:0]            rsp_red_first,
   output logic [7:0]            rsp_blue_second,
   output logic [7:0]            rsp_green_second,
   output logic [7:0]            rsp_red_second,
   // csr port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   offset_type ofs;

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] luma_first_ff;
   logic [7:0] luma_second_ff;
   logic [7:0] cb_first_ff;
   logic [7:0] cr_first_ff;
   logic [7:0] cb_second_ff;
   logic [7:0] cr_second_ff;

   // result register
   logic       out_valid_ff;
   logic [7:0] blue_first_ff;
   logic [7:0] green_first_ff;
   logic [7:0] red_first_ff;
   logic [7:0] blue_second_ff;
   logic [7:0] green_second_ff;
   logic [7:0] red_second_ff;

   logic [7:0] blue_first_in;
   logic [7:0] green_first_in;
   logic [7:0] red_first_in;
   logic [7:0] blue_second_in;
   logic [7:0] green_second_in;
   logic [7:0] red_second_in;

   // fully pipelined, never stalls
   assign busy        = 1'b0;
   assign in_valid_in = start && !busy;

   yprgb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload captured only on an accepted word
   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         luma_first_ff  <= req_luma_first;
         luma_second_ff <= req_luma_second;
         cb_first_ff    <= req_cb_first;
         cr_first_ff    <= req_cr_first;
         cb_second_ff   <= req_cb_second;
         cr_second_ff   <= req_cr_second;
      end
   end

   // chroma select/average and the three offsets, shared by both pixels
   yprgb_chroma u_chroma (
      .cb_first  (cb_first_ff),
      .cr_first  (cr_first_ff),
      .cb_second (cb_second_ff),
      .cr_second (cr_second_ff),
      .cfg       (cfg),
      .ofs       (ofs)
   );

   yprgb_pixel u_pixel_first (
      .luma       (luma_first_ff),
      .ofs        (ofs),
      .reduce_565 (cfg.reduce_565),
      .blue       (blue_first_in),
      .green      (green_first_in),
      .red        (red_first_in)
   );

   yprgb_pixel u_pixel_second (
      .luma       (luma_second_ff),
      .ofs        (ofs),
      .reduce_565 (cfg.reduce_565),
      .blue       (blue_second_in),
      .green      (green_second_in),
      .red        (red_second_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         blue_first_ff   <= blue_first_in;
         green_first_ff  <= green_first_in;
         red_first_ff    <= red_first_in;
         blue_second_ff  <= blue_second_in;
         green_second_ff <= green_second_in;
         red_second_ff   <= red_second_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_blue_first   = blue_first_ff;
   assign rsp_green_first  = green_first_ff;
   assign rsp_red_first    = red_first_ff;
   assign rsp_blue_second  = blue_second_ff;
   assign rsp_green_second = green_second_ff;
   assign rsp_red_second   = red_second_ff;

endmodule

@@ rtl/yprgb_checker.sv @@
`timescale 1ns / 1ps
`include "yuv_pair_to_rgb_converter_assert.svh"
module yprgb_checker
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // the pipeline never pushes back
   `YPRGB_ASSERT(a_never_busy, clock, !busy, "busy went high")

   // every accepted word gives a result after passing the input and result registers
   `YPRGB_ASSERT_RST(a_word_to_result, clock, reset, start && !busy |=> ##1 rsp_valid, "accepted word gave no result")

   // no result without a word accepted earlier that passed both registers
   `YPRGB_ASSERT_RST(a_no_phantom, clock, reset, rsp_valid |-> $past(start && !busy, 2), "result without an accepted word")

   // nothing comes out right after reset
   `YPRGB_ASSERT(a_quiet_after_reset, clock, $past(reset) |-> !rsp_valid, "result right after reset")

endmodule

bind yuv_pair_to_rgb_converter yprgb_checker u_yprgb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
